// ===== hdl/cac_pkg.sv =====
// shared types, constants and codes for the elevator car controller
package cac_pkg;

  localparam int unsigned FLOORS  = 16;
  localparam int unsigned FLOOR_W = $clog2(FLOORS);
  localparam int unsigned COUNT_W = FLOOR_W + 1;
  localparam int unsigned TICK_W  = 16;
  localparam int unsigned CFG_W   = 16;

  localparam logic [COUNT_W-1:0] FLOOR_COUNT_RST = COUNT_W'(16);
  localparam logic [TICK_W-1:0]  MOVE_TICKS_RST  = TICK_W'(600);
  localparam logic [TICK_W-1:0]  OPEN_TICKS_RST  = TICK_W'(1000);
  localparam logic [TICK_W-1:0]  HOLD_TICKS_RST  = TICK_W'(2000);
  localparam logic [TICK_W-1:0]  CLOSE_TICKS_RST = TICK_W'(1000);
  localparam logic [TICK_W-1:0]  ALARM_TICKS_RST = TICK_W'(3000);

  typedef enum logic [2:0] {
    OP_TICK      = 3'd0,
    OP_CABIN     = 3'd1,
    OP_HALL_UP   = 3'd2,
    OP_HALL_DOWN = 3'd3,
    OP_OPEN      = 3'd4,
    OP_CLOSE     = 3'd5,
    OP_ALARM     = 3'd6
  } op_e;

  typedef enum logic [2:0] {
    CFG_FLOOR_COUNT = 3'd0,
    CFG_MOVE_TICKS  = 3'd1,
    CFG_OPEN_TICKS  = 3'd2,
    CFG_HOLD_TICKS  = 3'd3,
    CFG_CLOSE_TICKS = 3'd4,
    CFG_ALARM_TICKS = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    REQ_CABIN = 2'd0,
    REQ_UP    = 2'd1,
    REQ_DOWN  = 2'd2
  } req_kind_e;

  typedef struct packed {
    logic [COUNT_W-1:0] floor_count;
    logic [TICK_W-1:0]  move_ticks;
    logic [TICK_W-1:0]  opening_ticks;
    logic [TICK_W-1:0]  hold_open_ticks;
    logic [TICK_W-1:0]  closing_ticks;
    logic [TICK_W-1:0]  alarm_ticks;
  } cac_cfg_t;

  // commands broadcast to every floor cell
  typedef struct packed {
    req_kind_e          req_kind;
    logic [FLOOR_W-1:0] req_floor;
    logic               set_en;
    logic               clr_en;
    logic [FLOOR_W-1:0] clr_floor;
    logic               trim_en;
    logic [COUNT_W-1:0] trim_count;
  } cac_cell_cmd_t;

  // request summary seen from the car's floor, plus the duplicate flag of the requested floor, carried along the row
  typedef struct packed {
    logic here;
    logic above;
    logic below;
    logic next_up;
    logic next_dn;
    logic dup;
  } cac_sum_t;

  typedef struct packed {
    logic [FLOOR_W-1:0] floor_now;
    logic [2:0]         car_state;
    logic [1:0]         travel_direction;
    logic               arrived;
    logic               alarm_raised;
    logic               request_ignored;
  } cac_status_t;

  typedef struct packed {
    cac_status_t       status;
    logic [FLOORS-1:0] cabin_lamps;
    logic [FLOORS-1:0] hall_up_lamps;
    logic [FLOORS-1:0] hall_down_lamps;
  } cac_result_t;

endpackage

// ===== hdl/cac_floor_cell.sv =====
// one floor cell: request bits of its floor and the request chains through it
module cac_floor_cell import cac_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [FLOOR_W-1:0] idx_i,
  input  logic [FLOOR_W-1:0] car_floor_i,
  input  cac_cell_cmd_t      cmd_i,
  input  logic               lo_any_i,
  input  logic               hi_any_i,
  input  logic               up_req_i,
  input  logic               dn_req_i,
  input  cac_sum_t           sum_i,
  output logic               lo_any_o,
  output logic               hi_any_o,
  output logic               req_o,
  output cac_sum_t           sum_o,
  output logic [2:0]         lamps_d_o
);

  logic cabin_q, up_q, down_q;
  logic cabin_d, up_d, down_d;
  logic sel_hit, set_hit, clr_hit, trim_hit, is_car, sel_bit;

  assign sel_hit  = (idx_i == cmd_i.req_floor);
  assign set_hit  = cmd_i.set_en & sel_hit;
  assign clr_hit  = cmd_i.clr_en & (idx_i == cmd_i.clr_floor);
  assign trim_hit = cmd_i.trim_en & ({1'b0, idx_i} >= cmd_i.trim_count);
  assign is_car   = (idx_i == car_floor_i);

  always_comb begin
    case (cmd_i.req_kind)
      REQ_CABIN: sel_bit = cabin_q;
      REQ_UP:    sel_bit = up_q;
      REQ_DOWN:  sel_bit = down_q;
      default:   sel_bit = 1'b0;
    endcase
  end

  assign cabin_d = (cabin_q | (set_hit & (cmd_i.req_kind == REQ_CABIN))) & ~clr_hit & ~trim_hit;
  assign up_d    = (up_q | (set_hit & (cmd_i.req_kind == REQ_UP))) & ~clr_hit & ~trim_hit;
  assign down_d  = (down_q | (set_hit & (cmd_i.req_kind == REQ_DOWN))) & ~clr_hit & ~trim_hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cabin_q <= 1'b0;
      up_q    <= 1'b0;
      down_q  <= 1'b0;
    end else begin
      cabin_q <= cabin_d;
      up_q    <= up_d;
      down_q  <= down_d;
    end
  end

  assign req_o     = cabin_q | up_q | down_q;
  assign lo_any_o  = lo_any_i | req_o;
  assign hi_any_o  = hi_any_i | req_o;
  assign lamps_d_o = {down_d, up_d, cabin_d};

  assign sum_o.here    = sum_i.here    | (is_car & req_o);
  assign sum_o.above   = sum_i.above   | (is_car & hi_any_i);
  assign sum_o.below   = sum_i.below   | (is_car & lo_any_i);
  assign sum_o.next_up = sum_i.next_up | (is_car & up_req_i);
  assign sum_o.next_dn = sum_i.next_dn | (is_car & dn_req_i);
  assign sum_o.dup     = sum_i.dup     | (sel_hit & sel_bit);

endmodule

// ===== hdl/cac_sequencer.sv =====
// car sequencer: mode, heading, floor, door and alarm timer, scan decisions
module cac_sequencer import cac_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  op_e                op_i,
  input  logic [FLOOR_W-1:0] floor_i,
  input  cac_cfg_t           cfg_i,
  input  cac_sum_t           sum_i,
  output cac_cell_cmd_t      cmd_o,
  output cac_status_t        status_o,
  output logic [FLOOR_W-1:0] car_floor_o
);

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_UP      = 3'd1,
    MODE_DOWN    = 3'd2,
    MODE_OPENING = 3'd3,
    MODE_OPEN    = 3'd4,
    MODE_CLOSING = 3'd5,
    MODE_ALARM   = 3'd6
  } mode_e;

  typedef enum logic [1:0] {
    HEAD_NONE = 2'd0,
    HEAD_UP   = 2'd1,
    HEAD_DOWN = 2'd2
  } heading_e;

  mode_e              mode_q, mode_d;
  heading_e           heading_q, heading_d;
  logic [FLOOR_W-1:0] floor_q, floor_d;
  logic [TICK_W-1:0]  count_q, count_d;
  logic               armed_q, armed_d;
  logic               alarm_q, alarm_d;
  logic               do_decide, here, above, below;
  logic               arrived, raised, ignored;

  always_comb begin
    mode_d           = mode_q;
    heading_d        = heading_q;
    floor_d          = floor_q;
    count_d          = count_q;
    armed_d          = armed_q;
    alarm_d          = alarm_q;
    arrived          = 1'b0;
    raised           = 1'b0;
    ignored          = 1'b0;
    do_decide        = 1'b0;
    here             = sum_i.here;
    above            = sum_i.above;
    below            = sum_i.below;
    cmd_o.req_floor  = floor_i;
    cmd_o.trim_en    = 1'b0;
    cmd_o.trim_count = '0;
    cmd_o.set_en     = 1'b0;
    cmd_o.clr_en     = 1'b0;
    cmd_o.clr_floor  = floor_q;
    case (op_i)
      OP_HALL_UP:   cmd_o.req_kind = REQ_UP;
      OP_HALL_DOWN: cmd_o.req_kind = REQ_DOWN;
      default:      cmd_o.req_kind = REQ_CABIN;
    endcase
    if (accept_i) begin
      unique case (op_i) inside
        OP_CABIN, OP_HALL_UP, OP_HALL_DOWN: begin
          if ({1'b0, floor_i} >= cfg_i.floor_count) begin
            ignored = 1'b1;
          end else if (sum_i.dup) begin
            ignored = 1'b1;
          end else if ((floor_i == floor_q) && ((op_i == OP_CABIN) ||
                       (mode_q == MODE_OPENING) || (mode_q == MODE_OPEN))) begin
            ignored = 1'b1;
          end else begin
            cmd_o.set_en = 1'b1;
            if (mode_q == MODE_IDLE) begin
              do_decide = 1'b1;
              here      = here | (floor_i == floor_q);
              above     = above | (floor_i > floor_q);
              below     = below | (floor_i < floor_q);
            end
          end
        end
        OP_OPEN: begin
          if ((mode_q == MODE_IDLE) || (mode_q == MODE_CLOSING) || (mode_q == MODE_OPEN)) begin
            mode_d  = MODE_OPENING;
            count_d = cfg_i.opening_ticks;
            armed_d = 1'b1;
          end
        end
        OP_CLOSE: begin
          if ((mode_q == MODE_OPEN) || (mode_q == MODE_OPENING)) begin
            mode_d  = MODE_CLOSING;
            count_d = cfg_i.closing_ticks;
            armed_d = 1'b1;
          end
        end
        OP_ALARM: begin
          if (!alarm_q) begin
            alarm_d   = 1'b1;
            mode_d    = MODE_ALARM;
            heading_d = HEAD_NONE;
            count_d   = cfg_i.alarm_ticks;
            armed_d   = 1'b1;
            raised    = 1'b1;
          end
        end
        default: begin
          if (armed_q) begin
            if (count_q <= TICK_W'(1)) begin
              armed_d = 1'b0;
              count_d = '0;
              unique case (mode_q) inside
                MODE_UP, MODE_DOWN: begin
                  if ((heading_q == HEAD_UP) && above) begin
                    floor_d = floor_q + FLOOR_W'(1);
                    mode_d  = MODE_UP;
                    armed_d = 1'b1;
                    if (sum_i.next_up) begin
                      cmd_o.clr_en    = 1'b1;
                      cmd_o.clr_floor = floor_d;
                      arrived         = 1'b1;
                      mode_d          = MODE_OPENING;
                      count_d         = cfg_i.opening_ticks;
                    end else begin
                      count_d = cfg_i.move_ticks;
                    end
                  end else if ((heading_q == HEAD_DOWN) && below) begin
                    floor_d = floor_q - FLOOR_W'(1);
                    mode_d  = MODE_DOWN;
                    armed_d = 1'b1;
                    if (sum_i.next_dn) begin
                      cmd_o.clr_en    = 1'b1;
                      cmd_o.clr_floor = floor_d;
                      arrived         = 1'b1;
                      mode_d          = MODE_OPENING;
                      count_d         = cfg_i.opening_ticks;
                    end else begin
                      count_d = cfg_i.move_ticks;
                    end
                  end else if ((heading_q == HEAD_UP) && below) begin
                    heading_d = HEAD_DOWN;
                    mode_d    = MODE_DOWN;
                    count_d   = cfg_i.move_ticks;
                    armed_d   = 1'b1;
                  end else if ((heading_q == HEAD_DOWN) && above) begin
                    heading_d = HEAD_UP;
                    mode_d    = MODE_UP;
                    count_d   = cfg_i.move_ticks;
                    armed_d   = 1'b1;
                  end else begin
                    do_decide = 1'b1;
                  end
                end
                MODE_OPENING: begin
                  mode_d  = MODE_OPEN;
                  count_d = cfg_i.hold_open_ticks;
                  armed_d = 1'b1;
                end
                MODE_OPEN: begin
                  mode_d  = MODE_CLOSING;
                  count_d = cfg_i.closing_ticks;
                  armed_d = 1'b1;
                end
                MODE_CLOSING: begin
                  do_decide = 1'b1;
                end
                MODE_ALARM: begin
                  alarm_d   = 1'b0;
                  do_decide = 1'b1;
                end
                default: begin
                end
              endcase
            end else begin
              count_d = count_q - TICK_W'(1);
            end
          end
        end
      endcase
      if (do_decide) begin
        if (here) begin
          cmd_o.clr_en    = 1'b1;
          cmd_o.clr_floor = floor_q;
          mode_d          = MODE_OPENING;
          heading_d       = HEAD_NONE;
          count_d         = cfg_i.opening_ticks;
          armed_d         = 1'b1;
        end else if (above) begin
          mode_d    = MODE_UP;
          heading_d = HEAD_UP;
          count_d   = cfg_i.move_ticks;
          armed_d   = 1'b1;
        end else if (below) begin
          mode_d    = MODE_DOWN;
          heading_d = HEAD_DOWN;
          count_d   = cfg_i.move_ticks;
          armed_d   = 1'b1;
        end else begin
          mode_d    = MODE_IDLE;
          heading_d = HEAD_NONE;
          count_d   = '0;
          armed_d   = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_IDLE;
      heading_q <= HEAD_NONE;
      floor_q   <= '0;
      count_q   <= '0;
      armed_q   <= 1'b0;
      alarm_q   <= 1'b0;
    end else begin
      mode_q    <= mode_d;
      heading_q <= heading_d;
      floor_q   <= floor_d;
      count_q   <= count_d;
      armed_q   <= armed_d;
      alarm_q   <= alarm_d;
    end
  end

  assign car_floor_o               = floor_q;
  assign status_o.floor_now        = floor_d;
  assign status_o.car_state        = mode_d;
  assign status_o.travel_direction = heading_d;
  assign status_o.arrived          = arrived;
  assign status_o.alarm_raised     = raised;
  assign status_o.request_ignored  = ignored;

endmodule

// ===== hdl/cac_out_queue.sv =====
// two-word result queue: output register plus skid stage
module cac_out_queue import cac_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  cac_result_t word_i,
  output logic        full_o,
  output logic        valid_o,
  input  logic        stall_i,
  output cac_result_t word_o
);

  logic        out_valid_q, skid_valid_q;
  cac_result_t out_q, skid_q;
  logic        take;

  assign take = out_valid_q & ~stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (take) begin
        if (skid_valid_q) begin
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= push_i;
        end
      end else if (push_i) begin
        if (out_valid_q) begin
          skid_valid_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && skid_valid_q) begin
      out_q <= skid_q;
    end else if (push_i && (take || !out_valid_q)) begin
      out_q <= word_i;
    end
    if (push_i && out_valid_q && !take) begin
      skid_q <= word_i;
    end
  end

  assign full_o  = skid_valid_q;
  assign valid_o = out_valid_q;
  assign word_o  = out_q;

endmodule

// ===== hdl/elevator_car_controller.sv =====
// top level of the elevator car controller: config, floor cell row, sequencer, result queue
//
//  channel   direction  handshake                 payload
//  in        to block   in_valid_i / in_stall_o   operation_i, floor_i
//  out       from block out_valid_o / out_stall_i floor_now_o .. request_ignored_o
//  cfg       to block   cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// one word is taken every cycle while in_stall_o is low; its result is registered in the result queue
// the request search ripples combinationally through one row of floor cells
// reset: car at floor 0, idle, no requests, registers at their defaults
// a two-word result queue stalls the input only when both words are waiting
module elevator_car_controller import cac_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         operation_i,
  input  logic [FLOOR_W-1:0] floor_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [FLOOR_W-1:0] floor_now_o,
  output logic [2:0]         car_state_o,
  output logic [1:0]         travel_direction_o,
  output logic               arrived_o,
  output logic               alarm_raised_o,
  output logic [FLOORS-1:0]  cabin_lamps_o,
  output logic [FLOORS-1:0]  hall_up_lamps_o,
  output logic [FLOORS-1:0]  hall_down_lamps_o,
  output logic               request_ignored_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [CFG_W-1:0]   cfg_data_i
);

  cac_cfg_t           cfg_q;
  logic               cfg_we, accept;
  cac_cell_cmd_t      seq_cmd, cell_cmd;
  cac_status_t        status;
  cac_result_t        result, out_word;
  logic [FLOOR_W-1:0] car_floor;
  logic [FLOORS:0]    lo_link, hi_link;
  logic [FLOORS+1:0]  req_pad;
  cac_sum_t           sum_link [FLOORS+1];
  logic [FLOORS-1:0]  cabin_d, up_d, down_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;
  assign accept      = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.floor_count     <= FLOOR_COUNT_RST;
      cfg_q.move_ticks      <= MOVE_TICKS_RST;
      cfg_q.opening_ticks   <= OPEN_TICKS_RST;
      cfg_q.hold_open_ticks <= HOLD_TICKS_RST;
      cfg_q.closing_ticks   <= CLOSE_TICKS_RST;
      cfg_q.alarm_ticks     <= ALARM_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        CFG_FLOOR_COUNT: cfg_q.floor_count     <= cfg_data_i[COUNT_W-1:0];
        CFG_MOVE_TICKS:  cfg_q.move_ticks      <= cfg_data_i[TICK_W-1:0];
        CFG_OPEN_TICKS:  cfg_q.opening_ticks   <= cfg_data_i[TICK_W-1:0];
        CFG_HOLD_TICKS:  cfg_q.hold_open_ticks <= cfg_data_i[TICK_W-1:0];
        CFG_CLOSE_TICKS: cfg_q.closing_ticks   <= cfg_data_i[TICK_W-1:0];
        CFG_ALARM_TICKS: cfg_q.alarm_ticks     <= cfg_data_i[TICK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // floor count writes drop requests at or above the new count
  always_comb begin
    cell_cmd            = seq_cmd;
    cell_cmd.trim_en    = cfg_we & (cfg_index_i == CFG_FLOOR_COUNT);
    cell_cmd.trim_count = cfg_data_i[COUNT_W-1:0];
  end

  cac_sequencer u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .op_i        (op_e'(operation_i)),
    .floor_i     (floor_i),
    .cfg_i       (cfg_q),
    .sum_i       (sum_link[FLOORS]),
    .cmd_o       (seq_cmd),
    .status_o    (status),
    .car_floor_o (car_floor)
  );

  assign lo_link[0]         = 1'b0;
  assign hi_link[FLOORS]    = 1'b0;
  assign req_pad[0]         = 1'b0;
  assign req_pad[FLOORS+1]  = 1'b0;
  assign sum_link[0]        = '0;

  for (genvar i = 0; i < FLOORS; i++) begin : g_cell
    cac_floor_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .idx_i       (FLOOR_W'(i)),
      .car_floor_i (car_floor),
      .cmd_i       (cell_cmd),
      .lo_any_i    (lo_link[i]),
      .hi_any_i    (hi_link[i+1]),
      .up_req_i    (req_pad[i+2]),
      .dn_req_i    (req_pad[i]),
      .sum_i       (sum_link[i]),
      .lo_any_o    (lo_link[i+1]),
      .hi_any_o    (hi_link[i]),
      .req_o       (req_pad[i+1]),
      .sum_o       (sum_link[i+1]),
      .lamps_d_o   ({down_d[i], up_d[i], cabin_d[i]})
    );
  end

  assign result.status          = status;
  assign result.cabin_lamps     = cabin_d;
  assign result.hall_up_lamps   = up_d;
  assign result.hall_down_lamps = down_d;

  cac_out_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .word_i  (result),
    .full_o  (in_stall_o),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .word_o  (out_word)
  );

  assign floor_now_o        = out_word.status.floor_now;
  assign car_state_o        = out_word.status.car_state;
  assign travel_direction_o = out_word.status.travel_direction;
  assign arrived_o          = out_word.status.arrived;
  assign alarm_raised_o     = out_word.status.alarm_raised;
  assign request_ignored_o  = out_word.status.request_ignored;
  assign cabin_lamps_o      = out_word.cabin_lamps;
  assign hall_up_lamps_o    = out_word.hall_up_lamps;
  assign hall_down_lamps_o  = out_word.hall_down_lamps;

  // both request chains must agree on whether anything is pending
  a_chain_agree : assert property (@(posedge clk_i) disable iff (!rst_ni)
    lo_link[FLOORS] == hi_link[0])
    else $error("request chains disagree");

  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted word produced no result");

  a_no_arrive_and_alarm : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> !(status.arrived && status.alarm_raised))
    else $error("arrival and alarm in one step");

  a_ignored_no_set : assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.request_ignored |-> !seq_cmd.set_en)
    else $error("ignored request was recorded");

endmodule

// ===== test/tb_top.sv =====
// self-checking testbench for the elevator car controller: directed and random event traffic
module tb_top;
  import cac_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_UP      = 3'd1;
  localparam logic [2:0] ST_DOWN    = 3'd2;
  localparam logic [2:0] ST_OPENING = 3'd3;
  localparam logic [2:0] ST_OPEN    = 3'd4;
  localparam logic [2:0] ST_CLOSING = 3'd5;
  localparam logic [2:0] ST_ALARM   = 3'd6;
  localparam logic [1:0] DIR_NONE   = 2'd0;
  localparam logic [1:0] DIR_UP     = 2'd1;
  localparam logic [1:0] DIR_DOWN   = 2'd2;
  localparam logic [2:0] OP_SPARE   = 3'd7;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [2:0]         operation_i = OP_TICK;
  logic [FLOOR_W-1:0] floor_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [FLOOR_W-1:0] floor_now_o;
  logic [2:0]         car_state_o;
  logic [1:0]         travel_direction_o;
  logic               arrived_o;
  logic               alarm_raised_o;
  logic [FLOORS-1:0]  cabin_lamps_o;
  logic [FLOORS-1:0]  hall_up_lamps_o;
  logic [FLOORS-1:0]  hall_down_lamps_o;
  logic               request_ignored_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = CFG_FLOOR_COUNT;
  logic [CFG_W-1:0]   cfg_data_i = '0;

  elevator_car_controller uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .operation_i       (operation_i),
    .floor_i           (floor_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .floor_now_o       (floor_now_o),
    .car_state_o       (car_state_o),
    .travel_direction_o(travel_direction_o),
    .arrived_o         (arrived_o),
    .alarm_raised_o    (alarm_raised_o),
    .cabin_lamps_o     (cabin_lamps_o),
    .hall_up_lamps_o   (hall_up_lamps_o),
    .hall_down_lamps_o (hall_down_lamps_o),
    .request_ignored_o (request_ignored_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  // car model state
  cac_cfg_t           car_cfg;
  logic [FLOOR_W-1:0] car_at;
  logic [2:0]         motion;
  logic [1:0]         dir;
  logic [FLOORS-1:0]  cab_req, up_req, dn_req;
  logic [TICK_W-1:0]  ticks_left;
  logic               timer_on, alarm_on, arrived_now;

  cac_result_t due_status_q[$];
  cac_result_t due;
  int          fail_count = 0;
  int          burst_left = 0;
  int          stall_window = 0;
  int          stall_style = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [FLOORS-1:0] live_mask(input logic [COUNT_W-1:0] n);
    if (n >= COUNT_W'(FLOORS)) return '1;
    return (FLOORS'(1) << n) - FLOORS'(1);
  endfunction

  function automatic void reset_model();
    car_cfg.floor_count     = FLOOR_COUNT_RST;
    car_cfg.move_ticks      = MOVE_TICKS_RST;
    car_cfg.opening_ticks   = OPEN_TICKS_RST;
    car_cfg.hold_open_ticks = HOLD_TICKS_RST;
    car_cfg.closing_ticks   = CLOSE_TICKS_RST;
    car_cfg.alarm_ticks     = ALARM_TICKS_RST;
    car_at = '0;
    motion = ST_IDLE;
    dir = DIR_NONE;
    cab_req = '0;
    up_req = '0;
    dn_req = '0;
    ticks_left = '0;
    timer_on = 1'b0;
    alarm_on = 1'b0;
    arrived_now = 1'b0;
  endfunction

  function automatic void apply_setting(input logic [2:0] idx, input logic [CFG_W-1:0] data);
    logic [FLOORS-1:0] keep;
    case (idx)
      CFG_FLOOR_COUNT: begin
        car_cfg.floor_count = data[COUNT_W-1:0];
        keep = live_mask(car_cfg.floor_count);
        cab_req &= keep;
        up_req &= keep;
        dn_req &= keep;
      end
      CFG_MOVE_TICKS:  car_cfg.move_ticks = data;
      CFG_OPEN_TICKS:  car_cfg.opening_ticks = data;
      CFG_HOLD_TICKS:  car_cfg.hold_open_ticks = data;
      CFG_CLOSE_TICKS: car_cfg.closing_ticks = data;
      CFG_ALARM_TICKS: car_cfg.alarm_ticks = data;
      default: ;
    endcase
  endfunction

  function automatic void arm(input logic [TICK_W-1:0] period);
    ticks_left = period;
    timer_on = 1'b1;
  endfunction

  function automatic void clear_floor();
    logic [FLOORS-1:0] here;
    here = FLOORS'(1) << car_at;
    cab_req &= ~here;
    up_req &= ~here;
    dn_req &= ~here;
  endfunction

  // pick the next action from the car's floor
  function automatic void plan_next();
    logic [FLOORS-1:0] pend, here, below;
    pend = cab_req | up_req | dn_req;
    here = FLOORS'(1) << car_at;
    below = here - FLOORS'(1);
    if (|(pend & here)) begin
      clear_floor();
      motion = ST_OPENING;
      dir = DIR_NONE;
      arm(car_cfg.opening_ticks);
    end else if (|(pend & ~(below | here))) begin
      motion = ST_UP;
      dir = DIR_UP;
      arm(car_cfg.move_ticks);
    end else if (|(pend & below)) begin
      motion = ST_DOWN;
      dir = DIR_DOWN;
      arm(car_cfg.move_ticks);
    end else begin
      motion = ST_IDLE;
      dir = DIR_NONE;
      timer_on = 1'b0;
      ticks_left = '0;
    end
  endfunction

  function automatic void step_floor();
    logic [FLOORS-1:0] pend, here, below;
    logic              up_any, dn_any, moved;
    pend = cab_req | up_req | dn_req;
    here = FLOORS'(1) << car_at;
    below = here - FLOORS'(1);
    up_any = |(pend & ~(below | here));
    dn_any = |(pend & below);
    moved = 1'b0;
    if (dir == DIR_UP && up_any) begin
      car_at = car_at + 1'b1;
      motion = ST_UP;
      moved = 1'b1;
    end else if (dir == DIR_DOWN && dn_any) begin
      car_at = car_at - 1'b1;
      motion = ST_DOWN;
      moved = 1'b1;
    end else if (dir == DIR_UP && dn_any) begin
      dir = DIR_DOWN;
      motion = ST_DOWN;
      arm(car_cfg.move_ticks);
    end else if (dir == DIR_DOWN && up_any) begin
      dir = DIR_UP;
      motion = ST_UP;
      arm(car_cfg.move_ticks);
    end else begin
      plan_next();
    end
    if (moved) begin
      if (|(pend & (FLOORS'(1) << car_at))) begin
        clear_floor();
        arrived_now = 1'b1;
        motion = ST_OPENING;
        arm(car_cfg.opening_ticks);
      end else begin
        arm(car_cfg.move_ticks);
      end
    end
  endfunction

  function automatic void phase_end();
    timer_on = 1'b0;
    ticks_left = '0;
    case (motion)
      ST_UP, ST_DOWN: step_floor();
      ST_OPENING: begin
        motion = ST_OPEN;
        arm(car_cfg.hold_open_ticks);
      end
      ST_OPEN: begin
        motion = ST_CLOSING;
        arm(car_cfg.closing_ticks);
      end
      ST_CLOSING: plan_next();
      ST_ALARM: begin
        alarm_on = 1'b0;
        motion = ST_IDLE;
        plan_next();
      end
      default: ;
    endcase
  endfunction

  // returns 1 when the request is dropped
  function automatic logic log_request(input logic [2:0] op, input logic [FLOOR_W-1:0] fl);
    logic [FLOORS-1:0] b, kind_set;
    if (COUNT_W'(fl) >= car_cfg.floor_count) return 1'b1;
    b = FLOORS'(1) << fl;
    kind_set = (op == OP_CABIN) ? cab_req : ((op == OP_HALL_UP) ? up_req : dn_req);
    if (|(kind_set & b)) return 1'b1;
    if (fl == car_at && (op == OP_CABIN || motion == ST_OPENING || motion == ST_OPEN))
      return 1'b1;
    case (op)
      OP_CABIN:   cab_req |= b;
      OP_HALL_UP: up_req |= b;
      default:    dn_req |= b;
    endcase
    if (motion == ST_IDLE) plan_next();
    return 1'b0;
  endfunction

  function automatic cac_result_t step_car(input logic [2:0] op, input logic [FLOOR_W-1:0] fl);
    cac_result_t r;
    logic        ign, raised;
    ign = 1'b0;
    raised = 1'b0;
    arrived_now = 1'b0;
    case (op)
      OP_CABIN, OP_HALL_UP, OP_HALL_DOWN: ign = log_request(op, fl);
      OP_OPEN: begin
        if (motion == ST_IDLE || motion == ST_CLOSING || motion == ST_OPEN) begin
          motion = ST_OPENING;
          arm(car_cfg.opening_ticks);
        end
      end
      OP_CLOSE: begin
        if (motion == ST_OPEN || motion == ST_OPENING) begin
          motion = ST_CLOSING;
          arm(car_cfg.closing_ticks);
        end
      end
      OP_ALARM: begin
        if (!alarm_on) begin
          alarm_on = 1'b1;
          motion = ST_ALARM;
          dir = DIR_NONE;
          arm(car_cfg.alarm_ticks);
          raised = 1'b1;
        end
      end
      default: begin
        if (timer_on) begin
          if (ticks_left <= 1) phase_end();
          else ticks_left = ticks_left - 1'b1;
        end
      end
    endcase
    r.status.floor_now = car_at;
    r.status.car_state = motion;
    r.status.travel_direction = dir;
    r.status.arrived = arrived_now;
    r.status.alarm_raised = raised;
    r.status.request_ignored = ign;
    r.cabin_lamps = cab_req;
    r.hall_up_lamps = up_req;
    r.hall_down_lamps = dn_req;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want_v,
                             input logic [15:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0h, got %0h", name, want_v, got_v);
      fail_count++;
    end
  endtask

  // result checking, then config and input words taken at this edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (due_status_q.size() == 0) begin
          $error("result word with no expectation waiting");
          fail_count++;
        end else begin
          due = due_status_q.pop_front();
          check_field("floor_now", 16'(due.status.floor_now), 16'(floor_now_o));
          check_field("car_state", 16'(due.status.car_state), 16'(car_state_o));
          check_field("travel_direction", 16'(due.status.travel_direction),
                      16'(travel_direction_o));
          check_field("arrived", 16'(due.status.arrived), 16'(arrived_o));
          check_field("alarm_raised", 16'(due.status.alarm_raised), 16'(alarm_raised_o));
          check_field("cabin_lamps", due.cabin_lamps, cabin_lamps_o);
          check_field("hall_up_lamps", due.hall_up_lamps, hall_up_lamps_o);
          check_field("hall_down_lamps", due.hall_down_lamps, hall_down_lamps_o);
          check_field("request_ignored", 16'(due.status.request_ignored),
                      16'(request_ignored_o));
        end
      end
      if (cfg_valid_i && cfg_ready_o) apply_setting(cfg_index_i, cfg_data_i);
      if (in_valid_i && !in_stall_o) begin
        due_status_q.insert(due_status_q.size(), step_car(operation_i, floor_i));
      end
    end
  end

  // receiver stall pattern, style changes every window
  always @(negedge clk_i) begin
    if (stall_window == 0) begin
      stall_window = $urandom_range(20, 200);
      stall_style = $urandom_range(0, 3);
    end
    stall_window--;
    case (stall_style)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 2) == 0);
      2: out_stall_i <= ((stall_window % 5) < 2);
      default: out_stall_i <= ($urandom_range(0, 9) < 7);
    endcase
  end

  // called and returns at a falling edge; valid stays high for a following word
  task automatic send_word(input logic [2:0] op, input logic [FLOOR_W-1:0] fl);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    operation_i <= op;
    floor_i <= fl;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (due_status_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [CFG_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  task automatic load_settings(input logic [CFG_W-1:0] fc, input logic [CFG_W-1:0] mv,
                               input logic [CFG_W-1:0] opn, input logic [CFG_W-1:0] hold,
                               input logic [CFG_W-1:0] cls, input logic [CFG_W-1:0] alm);
    drain();
    write_reg(CFG_FLOOR_COUNT, fc);
    write_reg(CFG_MOVE_TICKS, mv);
    write_reg(CFG_OPEN_TICKS, opn);
    write_reg(CFG_HOLD_TICKS, hold);
    write_reg(CFG_CLOSE_TICKS, cls);
    write_reg(CFG_ALARM_TICKS, alm);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [CFG_W-1:0] pick_ticks(input int unsigned hi);
    return CFG_W'($urandom_range(1, hi));
  endfunction

  // reset values: idle hall call at the car, door commands, duplicates
  task automatic test_default_requests();
    send_word(OP_TICK, 4'd0);
    send_word(OP_SPARE, 4'd15);
    send_word(OP_CABIN, 4'd0);
    send_word(OP_CLOSE, 4'd0);
    send_word(OP_HALL_UP, 4'd0);
    send_word(OP_HALL_DOWN, 4'd0);
    send_word(OP_OPEN, 4'd0);
    send_word(OP_CLOSE, 4'd0);
    send_word(OP_OPEN, 4'd0);
    send_word(OP_CABIN, 4'd15);
    send_word(OP_HALL_UP, 4'd3);
    send_word(OP_HALL_DOWN, 4'd3);
    send_word(OP_HALL_DOWN, 4'd3);
    send_word(OP_TICK, 4'd0);
  endtask

  // a floor count of two trims pending requests, longest periods
  task automatic test_extreme_settings();
    load_settings(CFG_W'(2), '1, '1, '1, '1, '1);
    send_word(OP_CABIN, 4'd1);
    send_word(OP_HALL_UP, 4'd2);
    send_word(OP_HALL_DOWN, 4'd15);
    send_word(OP_CLOSE, 4'd0);
    send_word(OP_OPEN, 4'd0);
  endtask

  task automatic test_door_and_alarm();
    load_settings(CFG_W'(16), CFG_W'(1), CFG_W'(1), CFG_W'(1), CFG_W'(1), CFG_W'(1));
    send_word(OP_CLOSE, 4'd0);
    send_word(OP_TICK, 4'd0);
    send_word(OP_ALARM, 4'd0);
    send_word(OP_ALARM, 4'd0);
    send_word(OP_HALL_DOWN, 4'd9);
    send_word(OP_TICK, 4'd0);
    send_word(OP_TICK, 4'd0);
  endtask

  task automatic test_random_traffic();
    int unsigned pick, req_pct;
    logic [2:0]  op;
    logic [3:0]  fl;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: load_settings(CFG_W'(16), CFG_W'(1), CFG_W'(1), CFG_W'(1), CFG_W'(1), CFG_W'(1));
        1: load_settings(CFG_W'(2), pick_ticks(3), pick_ticks(3), pick_ticks(3),
                         pick_ticks(3), pick_ticks(3));
        4: load_settings(CFG_W'(16), CFG_W'(1), pick_ticks(30), pick_ticks(30),
                         pick_ticks(30), pick_ticks(30));
        default: load_settings(CFG_W'($urandom_range(2, 16)), pick_ticks(8), pick_ticks(8),
                               pick_ticks(8), pick_ticks(8), pick_ticks(8));
      endcase
      req_pct = 15 + 4 * ph;
      for (int n = 0; n < 325; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < req_pct) op = 3'($urandom_range(OP_CABIN, OP_HALL_DOWN));
        else if (pick < req_pct + 4) op = OP_OPEN;
        else if (pick < req_pct + 8) op = OP_CLOSE;
        else if (pick < req_pct + 9) op = OP_ALARM;
        else if (pick < req_pct + 10) op = OP_SPARE;
        else op = OP_TICK;
        if ($urandom_range(0, 9) < 8) fl = 4'($urandom_range(0, car_cfg.floor_count - 1));
        else fl = 4'($urandom_range(0, 15));
        send_word(op, fl);
      end
    end
  endtask

  initial begin
    reset_model();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_default_requests();
    test_extreme_settings();
    test_door_and_alarm();
    test_random_traffic();
    drain();
    repeat (10) @(negedge clk_i);
    if (fail_count == 0 && due_status_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
